[rtl/mbps_pkg.sv]
// Shared types and constants for the masked byte pattern scanner.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package mbps_pkg;

    localparam int ADDR_W     = 48;
    localparam int PAT_MAX    = 16;
    localparam int LEN_W      = 5;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_CARE_MASK      = 3'd2,
        REG_PATTERN_LENGTH = 3'd3,
        REG_MATCH_LIMIT    = 3'd4,
        REG_BASE_ADDRESS   = 3'd5
    } t_reg_idx;

    // A match as it leaves the front end: offset of the window's first byte.
    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic              limit_reached;
    } t_match;

    // Handshake between front end and queue.
    typedef struct packed {
        logic   push;
        t_match item;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

[rtl/mbps_if.sv]
// Valid/ready channel interfaces for the scanner: input bytes, results and
// configuration writes. Depends on mbps_pkg for widths.
`timescale 1ns / 1ps

interface mbps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       restart;

    modport source (output valid, output data_byte, output restart, input ready);
    modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface mbps_out_if;
    logic                        valid;
    logic                        ready;
    logic [mbps_pkg::ADDR_W-1:0] match_address;
    logic                        limit_reached;

    modport source (output valid, output match_address, output limit_reached, input ready);
    modport sink   (input valid, input match_address, input limit_reached, output ready);
endinterface

interface mbps_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mbps_pkg::CFG_IDX_W-1:0]  index;
    logic [mbps_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/mbps_front.sv]
// Front end of the scanner: byte window, masked compare, counters and done.
// Depends on mbps_pkg; feeds matches to mbps_queue.
`timescale 1ns / 1ps

module mbps_front #(
    parameter int PATTERN_BYTES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_restart,
    input  logic [127:0]                  i_pattern,
    input  logic [mbps_pkg::PAT_MAX-1:0]  i_care_mask,
    input  logic [mbps_pkg::LEN_W-1:0]    i_pattern_length,
    input  logic [mbps_pkg::COUNT_W-1:0]  i_match_limit,
    output mbps_pkg::t_push               o_push
);

    localparam int WIN   = (PATTERN_BYTES < mbps_pkg::PAT_MAX) ? PATTERN_BYTES
                                                               : mbps_pkg::PAT_MAX;
    localparam int IDX_W = (WIN > 1) ? $clog2(WIN) : 1;
    localparam logic [mbps_pkg::LEN_W-1:0] WIN_LEN = mbps_pkg::LEN_W'(WIN);

    logic [7:0]                     r_window [WIN];
    logic [mbps_pkg::ADDR_W-1:0]    r_seen;
    logic [mbps_pkg::COUNT_W-1:0]   r_total;
    logic                           r_done;

    logic [7:0]                     n_window [WIN];
    logic [mbps_pkg::ADDR_W-1:0]    n_seen;
    logic [mbps_pkg::COUNT_W-1:0]   n_total;
    logic                           n_done;

    logic [mbps_pkg::ADDR_W-1:0]    base_seen;
    logic [mbps_pkg::COUNT_W-1:0]   base_total;
    logic                           base_done;
    logic [mbps_pkg::ADDR_W-1:0]    step_seen;
    logic [mbps_pkg::COUNT_W-1:0]   step_total;
    logic [mbps_pkg::LEN_W-1:0]     eff_len;
    logic [mbps_pkg::LEN_W-1:0]     sel_full;
    logic [IDX_W-1:0]               sel;
    logic                           enough;
    logic                           hit;
    logic                           at_limit;

    always_comb begin
        // Restart clears the scan state before this byte is taken.
        base_seen  = i_restart ? '0 : r_seen;
        base_total = i_restart ? '0 : r_total;
        base_done  = i_restart ? 1'b0 : r_done;

        if (i_pattern_length == '0) begin
            eff_len = mbps_pkg::LEN_W'(1);
        end else if (i_pattern_length > WIN_LEN) begin
            eff_len = WIN_LEN;
        end else begin
            eff_len = i_pattern_length;
        end

        n_window[0] = i_data_byte;
        for (int k = 1; k < WIN; k++) begin
            n_window[k] = r_window[k-1];
        end

        step_seen = base_seen + mbps_pkg::ADDR_W'(1);
        enough = (step_seen[mbps_pkg::ADDR_W-1:mbps_pkg::LEN_W] != '0) ||
                 (step_seen[mbps_pkg::LEN_W-1:0] >= eff_len);

        // Pattern byte i sits at window position len-1-i, counted from the newest.
        hit = 1'b1;
        sel_full = '0;
        sel = '0;
        for (int i = 0; i < WIN; i++) begin
            sel_full = eff_len - mbps_pkg::LEN_W'(1) - mbps_pkg::LEN_W'(i);
            sel = sel_full[IDX_W-1:0];
            if ((mbps_pkg::LEN_W'(i) < eff_len) && i_care_mask[i] &&
                (n_window[sel] != i_pattern[8*i +: 8])) begin
                hit = 1'b0;
            end
        end
        hit = hit && enough && !base_done;

        step_total = (base_total != '1) ? base_total + mbps_pkg::COUNT_W'(1) : base_total;
        at_limit = (i_match_limit != '0) && (step_total == i_match_limit);

        n_seen  = base_done ? base_seen : step_seen;
        n_total = hit ? step_total : base_total;
        n_done  = base_done || (hit && at_limit);

        o_push.push               = i_accept && hit;
        o_push.item.offset        = step_seen - mbps_pkg::ADDR_W'(eff_len);
        o_push.item.limit_reached = at_limit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_total <= '0;
            r_done  <= 1'b0;
        end else if (i_accept) begin
            r_seen  <= n_seen;
            r_total <= n_total;
            r_done  <= n_done;
        end
    end

    // Window bytes are never compared before enough bytes have replaced them.
    always_ff @(posedge i_clk) begin
        if (i_accept && !base_done) begin
            r_window <= n_window;
        end
    end

endmodule

[rtl/mbps_queue.sv]
// Short match queue between the scanner front end and the output stage.
// Depends on mbps_pkg for the match type and depth.
`timescale 1ns / 1ps

module mbps_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mbps_pkg::t_push         i_push,
    input  logic                    i_pop,
    output mbps_pkg::t_match        o_head,
    output mbps_pkg::t_queue_status o_status
);

    localparam int PTR_W = (mbps_pkg::QUEUE_DEPTH > 1) ? $clog2(mbps_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(mbps_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(mbps_pkg::QUEUE_DEPTH);

    mbps_pkg::t_match r_mem [mbps_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == DEPTH_CNT);
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(mbps_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(mbps_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : r_rd_ptr + 1'b1;
            end
            if (i_push.push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> (r_count != DEPTH_CNT))
        else $error("match queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("match queue read while empty");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("match queue count lost a push");

endmodule

[rtl/mbps_back.sv]
// Output stage of the scanner: forms the match address and holds the result.
// Depends on mbps_pkg; drains mbps_queue.
`timescale 1ns / 1ps

module mbps_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mbps_pkg::t_match            i_head,
    input  mbps_pkg::t_queue_status     i_status,
    input  logic [mbps_pkg::ADDR_W-1:0] i_base_address,
    output logic                        o_pop,
    mbps_out_if.source                  o_out
);

    logic                        r_valid;
    logic [mbps_pkg::ADDR_W-1:0] r_address;
    logic                        r_limit;

    assign o_pop               = !i_status.empty && (!r_valid || o_out.ready);
    assign o_out.valid         = r_valid;
    assign o_out.match_address = r_address;
    assign o_out.limit_reached = r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_address <= i_base_address + i_head.offset;
            r_limit   <= i_head.limit_reached;
        end
    end

endmodule

[rtl/masked_byte_pattern_scanner.sv]
// Top level of the masked byte pattern scanner: configuration registers and
// the front end, match queue and output stage. Depends on mbps_pkg and mbps_if.
`timescale 1ns / 1ps

// The scanner takes one byte per clock cycle and reports the address of every
// window of the last pattern_length bytes that equals the programmed pattern in
// its care bytes. A byte is compared in the cycle it is accepted, and a match is
// written into the queue at that same edge and passes on to the output register
// when it is empty or being read; the match counter and the done flag
// are settled at the accepting edge, which lets the next byte follow at once.
// A two-entry match queue and the output register decouple the byte input from
// the result output: the input stalls only while both queue entries hold
// matches, which can only happen after the output has been stalled.
// Configuration is written through its own channel, which is always ready, and
// should only be changed while idle.
module masked_byte_pattern_scanner #(
    parameter int PATTERN_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbps_in_if.sink     i_in,
    mbps_cfg_if.sink    i_cfg,
    mbps_out_if.source  o_out
);

    logic [63:0]                        r_pattern_low;
    logic [63:0]                        r_pattern_high;
    logic [mbps_pkg::PAT_MAX-1:0]       r_care_mask;
    logic [mbps_pkg::LEN_W-1:0]         r_pattern_length;
    logic [mbps_pkg::COUNT_W-1:0]       r_match_limit;
    logic [mbps_pkg::ADDR_W-1:0]        r_base_address;

    mbps_pkg::t_push         push;
    mbps_pkg::t_match        head;
    mbps_pkg::t_queue_status status;
    logic                    pop;
    logic                    accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !status.full;
    assign accept      = i_in.valid && !status.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_care_mask      <= '0;
            r_pattern_length <= mbps_pkg::LEN_W'(1);
            r_match_limit    <= '0;
            r_base_address   <= '0;
        end else if (i_cfg.valid) begin
            unique case (mbps_pkg::t_reg_idx'(i_cfg.index))
                mbps_pkg::REG_PATTERN_LOW:    r_pattern_low    <= i_cfg.data;
                mbps_pkg::REG_PATTERN_HIGH:   r_pattern_high   <= i_cfg.data;
                mbps_pkg::REG_CARE_MASK:
                    r_care_mask <= i_cfg.data[mbps_pkg::PAT_MAX-1:0];
                mbps_pkg::REG_PATTERN_LENGTH:
                    r_pattern_length <= i_cfg.data[mbps_pkg::LEN_W-1:0];
                mbps_pkg::REG_MATCH_LIMIT:
                    r_match_limit <= i_cfg.data[mbps_pkg::COUNT_W-1:0];
                mbps_pkg::REG_BASE_ADDRESS:
                    r_base_address <= i_cfg.data[mbps_pkg::ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    mbps_front #(
        .PATTERN_BYTES (PATTERN_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_in.data_byte),
        .i_restart        (i_in.restart),
        .i_pattern        ({r_pattern_high, r_pattern_low}),
        .i_care_mask      (r_care_mask),
        .i_pattern_length (r_pattern_length),
        .i_match_limit    (r_match_limit),
        .o_push           (push)
    );

    mbps_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    mbps_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_status       (status),
        .i_base_address (r_base_address),
        .o_pop          (pop),
        .o_out          (o_out)
    );

endmodule

[dv/masked_byte_pattern_scanner_tb.sv]
// Self-checking testbench for the masked byte pattern scanner: a directed table
// followed by random phases under several settings.
// Depends on mbps_pkg, the channel interfaces in mbps_if and the scanner RTL.
`timescale 1ns / 1ps

module masked_byte_pattern_scanner_tb;

    localparam int ADDR_W     = mbps_pkg::ADDR_W;
    localparam int PAT_MAX    = mbps_pkg::PAT_MAX;
    localparam int LEN_W      = mbps_pkg::LEN_W;
    localparam int COUNT_W    = mbps_pkg::COUNT_W;
    localparam int CFG_IDX_W  = mbps_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = mbps_pkg::CFG_DATA_W;

    localparam int WINDOW_BYTES    = 16;
    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 8;
    localparam int END_CYCLES      = 20;
    localparam int CYCLE_LIMIT     = 1_500_000;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int LONG_HOLD       = 300;
    localparam int DIRECTED_ROWS   = 40;

    // Indexes past the end of the register list; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              at_limit;
    } t_hit;

    typedef enum logic [0:0] {ROW_CFG, ROW_BYTE} t_row_kind;
    typedef enum logic [1:0] {OUT_NONE, OUT_HIT, OUT_PREDICTED} t_row_outcome;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] value;
        logic [7:0]            data_byte;
        logic                  restart;
        t_row_outcome          outcome;
        logic [ADDR_W-1:0]     address;
        logic                  at_limit;
    } t_row;

    // Register rows use index and value; byte rows use the remaining fields.
    localparam t_row STIM_TABLE [DIRECTED_ROWS] = '{
        '{ROW_BYTE, '0, '0, 8'h00, 1'b0, OUT_HIT, 48'h0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, OUT_HIT, 48'h1, 1'b0},
        '{ROW_BYTE, '0, '0, 8'hA5, 1'b1, OUT_HIT, 48'h0, 1'b0},
        '{ROW_CFG, mbps_pkg::REG_MATCH_LIMIT, 64'hABCD_0000_0000_0001,
          '0, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'h3C, 1'b1, OUT_HIT, 48'h0, 1'b1},
        '{ROW_BYTE, '0, '0, 8'h11, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'h22, 1'b1, OUT_HIT, 48'h0, 1'b1},
        '{ROW_CFG, mbps_pkg::REG_MATCH_LIMIT, 64'h0,
          '0, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_CFG, mbps_pkg::REG_BASE_ADDRESS, 64'hFFFF_FFFF_FFFF_FFFF,
          '0, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'h00, 1'b1, OUT_HIT, 48'hFFFF_FFFF_FFFF, 1'b0},
        '{ROW_BYTE, '0, '0, 8'h01, 1'b0, OUT_HIT, 48'h0, 1'b0},
        '{ROW_CFG, mbps_pkg::REG_BASE_ADDRESS, 64'h1000,
          '0, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_CFG, mbps_pkg::REG_PATTERN_LOW, 64'h5A5A_5A5A_00FF_80C3,
          '0, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_CFG, mbps_pkg::REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF,
          '0, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_CFG, mbps_pkg::REG_PATTERN_LENGTH, 64'h0,
          '0, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_CFG, mbps_pkg::REG_CARE_MASK, 64'hFFFF_FFFF_FFFF_0001,
          '0, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'hC3, 1'b1, OUT_HIT, 48'h1000, 1'b0},
        '{ROW_BYTE, '0, '0, 8'hC2, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_CFG, mbps_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFE3,
          '0, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_CFG, mbps_pkg::REG_CARE_MASK, 64'h5,
          '0, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'hC3, 1'b1, OUT_NONE, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'h00, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, OUT_HIT, 48'h1000, 1'b0},
        '{ROW_BYTE, '0, '0, 8'hC3, 1'b0, OUT_PREDICTED, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'h80, 1'b0, OUT_PREDICTED, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, OUT_PREDICTED, '0, 1'b0},
        '{ROW_CFG, REG_SPARE_6, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_CFG, REG_SPARE_7, 64'hFFFF_FFFF_FFFF_FFFF, '0, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'hC3, 1'b0, OUT_PREDICTED, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'h80, 1'b0, OUT_PREDICTED, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'hFF, 1'b0, OUT_PREDICTED, '0, 1'b0},
        '{ROW_CFG, mbps_pkg::REG_PATTERN_LENGTH, 64'h1F,
          '0, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_CFG, mbps_pkg::REG_CARE_MASK, 64'h0,
          '0, 1'b0, OUT_NONE, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'h01, 1'b0, OUT_PREDICTED, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'h02, 1'b0, OUT_PREDICTED, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'h04, 1'b0, OUT_PREDICTED, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'h08, 1'b0, OUT_PREDICTED, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'h10, 1'b0, OUT_PREDICTED, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'h20, 1'b0, OUT_PREDICTED, '0, 1'b0},
        '{ROW_BYTE, '0, '0, 8'h40, 1'b0, OUT_PREDICTED, '0, 1'b0}
    };

    logic clk;
    logic rst_n;

    mbps_in_if  bytes_ch ();
    mbps_cfg_if cfg_ch ();
    mbps_out_if hits_ch ();

    masked_byte_pattern_scanner #(
        .PATTERN_BYTES(WINDOW_BYTES)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (bytes_ch),
        .i_cfg   (cfg_ch),
        .o_out   (hits_ch)
    );

    // Register copies and scan state of the predictor.
    logic [CFG_DATA_W-1:0] pat_lo        = '0;
    logic [CFG_DATA_W-1:0] pat_hi        = '0;
    logic [PAT_MAX-1:0]    care_bits     = '0;
    logic [LEN_W-1:0]      len_setting   = LEN_W'(1);
    logic [COUNT_W-1:0]    limit_setting = '0;
    logic [ADDR_W-1:0]     base_addr     = '0;

    logic [7:0]         scan_window [PAT_MAX] = '{default: 8'h00};
    logic [ADDR_W-1:0]  scan_count   = '0;
    logic [COUNT_W-1:0] hit_count    = '0;
    logic               scan_stopped = 1'b0;

    t_hit pending_hits [$];
    bit   any_failure     = 1'b0;
    bit   tx_idle_en      = 1'b1;
    bit   rx_idle_en      = 1'b1;
    int   rx_hold_request = 0;
    int   scanned_items   = 0;
    int   cycle_count     = 0;

    function automatic int active_length();
        int n;
        n = (len_setting == 0) ? 1 : int'(len_setting);
        if (n > PAT_MAX) n = PAT_MAX;
        if (n > WINDOW_BYTES) n = WINDOW_BYTES;
        return n;
    endfunction

    function automatic logic [7:0] pattern_byte_at(int i);
        logic [2*CFG_DATA_W-1:0] both;
        both = {pat_hi, pat_lo};
        return both[i*8 +: 8];
    endfunction

    // Appends one expected result to the back of the list.
    function automatic void queue_expected(input t_hit h);
        pending_hits = {pending_hits, h};
    endfunction

    // Advances the scan by one accepted byte and says whether it yields a match.
    function automatic void scan_next_byte(input logic [7:0] b, input logic clr,
            output bit taken, output bit found, output t_hit hit);
        int len;
        bit same;
        taken = 1'b0;
        found = 1'b0;
        hit   = '0;
        if (clr) begin
            foreach (scan_window[i]) scan_window[i] = 8'h00;
            scan_count   = '0;
            hit_count    = '0;
            scan_stopped = 1'b0;
        end
        if (scan_stopped) return;
        taken = 1'b1;
        for (int i = PAT_MAX - 1; i > 0; i--) scan_window[i] = scan_window[i-1];
        scan_window[0] = b;
        scan_count = scan_count + 1'b1;
        len = active_length();
        if (scan_count < ADDR_W'(len)) return;
        same = 1'b1;
        // The oldest byte of the window lines up with pattern byte 0.
        for (int i = 0; i < len; i++) begin
            if (care_bits[i] && scan_window[len-1-i] != pattern_byte_at(i)) same = 1'b0;
        end
        if (!same) return;
        if (hit_count != '1) hit_count = hit_count + 1'b1;
        hit.at_limit = (limit_setting != 0) && (hit_count == limit_setting);
        if (hit.at_limit) scan_stopped = 1'b1;
        hit.address = base_addr + scan_count - ADDR_W'(len);
        found = 1'b1;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic pick_restart();
        if (scan_stopped) return $urandom_range(0, 3) == 0;
        return $urandom_range(0, 99) == 0;
    endfunction

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Result side: random stalls, plus a long hold-off when the stimulus asks.
    initial begin : result_sink
        int hold;
        hold = 0;
        hits_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_request > 0) begin
                hold = rx_hold_request;
                rx_hold_request = 0;
            end
            if (hold > 0) begin
                hits_ch.ready <= 1'b0;
                hold--;
            end else begin
                hits_ch.ready <= 1'b1;
                if (rx_idle_en && $urandom_range(0, 2) == 0) hold = idle_len();
            end
        end
    end

    always @(posedge clk) begin : check_hits
        t_hit want;
        if (rst_n && hits_ch.valid && hits_ch.ready) begin
            if (pending_hits.size() == 0) begin
                $error("unexpected item: match_address %h limit_reached %b",
                       hits_ch.match_address, hits_ch.limit_reached);
                any_failure = 1'b1;
            end else begin
                want = pending_hits.pop_front();
                if (hits_ch.match_address !== want.address) begin
                    $error("match_address: expected %h, actual %h",
                           want.address, hits_ch.match_address);
                    any_failure = 1'b1;
                end
                if (hits_ch.limit_reached !== want.at_limit) begin
                    $error("limit_reached: expected %b, actual %b",
                           want.at_limit, hits_ch.limit_reached);
                    any_failure = 1'b1;
                end
            end
        end
    end

    // Entered and left on a rising edge; valid is touched at most once per edge.
    task automatic offer_byte(input logic [7:0] b, input logic clr,
            output bit taken, output bit found, output t_hit hit);
        int gap;
        gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            bytes_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        bytes_ch.valid     <= 1'b1;
        bytes_ch.data_byte <= b;
        bytes_ch.restart   <= clr;
        do @(posedge clk); while (!bytes_ch.ready);
        scan_next_byte(b, clr, taken, found, hit);
    endtask

    task automatic feed_byte(input logic [7:0] b, input logic clr);
        bit   taken;
        bit   found;
        t_hit hit;
        offer_byte(b, clr, taken, found, hit);
        if (found) queue_expected(hit);
        if (taken) scanned_items++;
    endtask

    task automatic wait_for_results();
        bytes_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_hits.size() != 0);
    endtask

    // Non-matching bytes leave nothing to wait for, so allow for the pipeline too.
    task automatic settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        case (idx)
            mbps_pkg::REG_PATTERN_LOW:    pat_lo = val;
            mbps_pkg::REG_PATTERN_HIGH:   pat_hi = val;
            mbps_pkg::REG_CARE_MASK:      care_bits = val[PAT_MAX-1:0];
            mbps_pkg::REG_PATTERN_LENGTH: len_setting = val[LEN_W-1:0];
            mbps_pkg::REG_MATCH_LIMIT:    limit_setting = val[COUNT_W-1:0];
            mbps_pkg::REG_BASE_ADDRESS:   base_addr = val[ADDR_W-1:0];
            default: ;
        endcase
    endtask

    // Mostly copies of the pattern with random wildcard bytes, some of them cut
    // short or corrupted, mixed with noise and runs of single pattern bytes.
    task automatic offer_burst();
        int kind;
        int len;
        int cut;
        int bad;
        int n;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        len  = active_length();
        if (kind < 55) begin
            cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : len;
            bad = ($urandom_range(0, 6) == 0) ? $urandom_range(0, len - 1) : -1;
            for (int i = 0; i < cut; i++) begin
                b = care_bits[i] ? pattern_byte_at(i) : 8'($urandom);
                if (i == bad) b = b ^ 8'($urandom_range(1, 255));
                feed_byte(b, pick_restart());
            end
        end else if (kind < 85) begin
            n = $urandom_range(1, 8);
            repeat (n) feed_byte(8'($urandom), pick_restart());
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) feed_byte(pattern_byte_at($urandom_range(0, len - 1)), pick_restart());
        end
    endtask

    initial begin : stimulus
        t_row row;
        bit   taken;
        bit   found;
        t_hit hit;
        int   phase_start;
        bit   paused;
        logic [CFG_DATA_W-1:0] len_val;
        logic [CFG_DATA_W-1:0] care_val;
        logic [CFG_DATA_W-1:0] limit_val;
        logic [CFG_DATA_W-1:0] base_val;

        rst_n              <= 1'b0;
        bytes_ch.valid     <= 1'b0;
        bytes_ch.data_byte <= '0;
        bytes_ch.restart   <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (STIM_TABLE[k]) begin
            row = STIM_TABLE[k];
            if (row.kind == ROW_CFG) begin
                settle();
                cfg_write(row.index, row.value);
            end else begin
                offer_byte(row.data_byte, row.restart, taken, found, hit);
                case (row.outcome)
                    OUT_HIT:       queue_expected(t_hit'{row.address, row.at_limit});
                    OUT_PREDICTED: if (found) queue_expected(hit);
                    default: ;
                endcase
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            // Random bits above each field check that the block drops them.
            len_val   = {$urandom, $urandom};
            care_val  = {$urandom, $urandom};
            limit_val = {$urandom, $urandom};
            base_val  = {$urandom, $urandom};
            case (phase % 5)
                0: len_val[LEN_W-1:0] = LEN_W'(1);
                1: len_val[LEN_W-1:0] = LEN_W'(PAT_MAX);
                2: len_val[LEN_W-1:0] = '0;
                3: len_val[LEN_W-1:0] = '1;
                default: ;
            endcase
            if (phase % 3 == 1) care_val[PAT_MAX-1:0] = '1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: limit_val[COUNT_W-1:0] = '0;
                4:          limit_val[COUNT_W-1:0] = COUNT_W'(1);
                5:          limit_val[COUNT_W-1:0] = '1;
                default:    limit_val[COUNT_W-1:0] = COUNT_W'($urandom_range(2, 12));
            endcase
            case ($urandom_range(0, 3))
                0:       base_val[ADDR_W-1:0] = '0;
                1:       base_val[ADDR_W-1:0] = '1;
                default: ;
            endcase
            // The first phase matches every byte, so a long hold-off fills the block.
            if (phase == 0) begin
                care_val[PAT_MAX-1:0]  = '0;
                limit_val[COUNT_W-1:0] = '0;
            end
            cfg_write(mbps_pkg::REG_PATTERN_LOW, {$urandom, $urandom});
            cfg_write(mbps_pkg::REG_PATTERN_HIGH, {$urandom, $urandom});
            cfg_write(mbps_pkg::REG_CARE_MASK, care_val);
            cfg_write(mbps_pkg::REG_PATTERN_LENGTH, len_val);
            cfg_write(mbps_pkg::REG_MATCH_LIMIT, limit_val);
            cfg_write(mbps_pkg::REG_BASE_ADDRESS, base_val);

            tx_idle_en = (phase != 0) && ($urandom_range(0, 3) != 0);
            rx_idle_en = $urandom_range(0, 3) != 0;
            if (phase == 0) rx_hold_request = LONG_HOLD;

            phase_start = scanned_items;
            paused = 1'b0;
            while (scanned_items - phase_start < ITEMS_PER_PHASE) begin
                if (!paused && scanned_items - phase_start >= ITEMS_PER_PHASE / 2) begin
                    wait_for_results();
                    paused = 1'b1;
                end
                offer_burst();
            end
        end

        settle();
        repeat (END_CYCLES) @(posedge clk);
        if (!any_failure) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/mbps_pkg.sv
rtl/mbps_if.sv
rtl/mbps_front.sv
rtl/mbps_queue.sv
rtl/mbps_back.sv
rtl/masked_byte_pattern_scanner.sv
dv/masked_byte_pattern_scanner_tb.sv
